/* src/camera_position_unit_core_assert.svh */
// assertion macros shared by the camera position unit
`ifndef CAMERA_POSITION_UNIT_CORE_ASSERT_SVH
`define CAMERA_POSITION_UNIT_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define CAMPOS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CAMPOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/campos_pkg.sv */
// shared types and constants of the camera position unit
package campos_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_W      = 24;
  localparam int POINT_W      = 24;
  localparam int STEP_W       = 16;
  localparam int BOX_W        = 20;
  localparam int WIN_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int FRAC_BITS    = 8;
  localparam int VEC_SCALE    = 24;
  localparam int ROT_FRAC     = 30;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int VEC_W   = DIFF_W + VEC_SCALE + 3;
  localparam int ROT_W   = STEP_W + ROT_FRAC + 3;
  localparam int MUL_B_W = ROT_FRAC;
  localparam int MUL_W   = STEP_W + MUL_B_W;
  localparam int ACC_W   = 2 * STEP_W + 1;
  localparam int ITER_W  = $clog2(CORDIC_STEPS);

  localparam logic [MUL_B_W-1:0] GAIN_INV = MUL_B_W'(652032874);
  localparam logic signed [ROT_W-1:0] ROT_HALF = ROT_W'(1) << (ROT_FRAC - 1);

  localparam logic [WIN_W-1:0] WIDTH_RESET  = WIN_W'(640);
  localparam logic [WIN_W-1:0] HEIGHT_RESET = WIN_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_MOVE  = 3'd1,
    OP_SHIFT = 3'd2,
    OP_W2S   = 3'd3,
    OP_S2W   = 3'd4,
    OP_GET   = 3'd5
  } op_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic diff;
    logic sq_x;
    logic sq_y;
    logic sq_r;
    logic snap;
    logic gain;
    logic rot_init;
    logic iterate;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_move;
    logic snap_hit;
    logic last_iter;
    logic out_free;
  } status_t;

endpackage

/* src/campos_ctrl.sv */
// sequencer of the camera position unit
module campos_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  campos_pkg::status_t status,
  output campos_pkg::cmd_t    cmd
);
  import campos_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_SQX   = 10'b0000000100,
    S_SQY   = 10'b0000001000,
    S_SQR   = 10'b0000010000,
    S_CMP   = 10'b0000100000,
    S_GAIN  = 10'b0001000000,
    S_ITER  = 10'b0010000000,
    S_FINAL = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.is_move) begin
          cmd.diff   = 1'b1;
          state_next = S_SQX;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = S_SQR;
      end
      S_SQR: begin
        cmd.sq_r   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.snap_hit) begin
          cmd.snap   = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.gain   = 1'b1;
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.rot_init = 1'b1;
        state_next   = S_ITER;
      end
      S_ITER: begin
        cmd.iterate = 1'b1;
        if (status.last_iter) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/campos_dp.sv */
// datapath of the camera position unit: camera, shared multiplier, cordic, result register
module campos_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  campos_pkg::cmd_t                       cmd,
  output campos_pkg::status_t                    status,
  input  logic                                   cfg_write,
  input  logic [campos_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [campos_pkg::WIN_W-1:0]           cfg_data,
  input  logic [2:0]                             opcode,
  input  logic signed [campos_pkg::POINT_W-1:0]  point_x,
  input  logic signed [campos_pkg::POINT_W-1:0]  point_y,
  input  logic [campos_pkg::STEP_W-1:0]          step_length,
  input  logic [campos_pkg::BOX_W-1:0]           box_width,
  input  logic [campos_pkg::BOX_W-1:0]           box_height,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [campos_pkg::POINT_W-1:0]  result_x,
  output logic signed [campos_pkg::POINT_W-1:0]  result_y,
  output logic [campos_pkg::BOX_W-1:0]           result_width,
  output logic [campos_pkg::BOX_W-1:0]           result_height
);
  import campos_pkg::*;

  // captured item
  op_t                       op;
  logic signed [COORD_W-1:0] px, py;
  logic [STEP_W-1:0]         r;
  logic [BOX_W-1:0]          bw, bh;

  logic [WIN_W-1:0]          window_width, window_height;
  logic signed [COORD_W-1:0] cam_x, cam_y;

  // move-toward working registers
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [STEP_W-1:0]         ax, ay;
  logic                      in_span;
  logic                      flip;
  logic [ACC_W-1:0]          acc;
  logic [MUL_W-1:0]          prod;
  logic signed [VEC_W-1:0]   vx, vy;
  logic signed [ROT_W-1:0]   rx, ry;
  logic [ITER_W-1:0]         iter;

  logic signed [DIFF_W-1:0]  dx_c, dy_c, adx_c, ady_c, dxf_c, dyf_c;
  logic [STEP_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [VEC_W-1:0]   vx_sh, vy_sh, vx_next, vy_next;
  logic signed [ROT_W-1:0]   rx_sh, ry_sh, rx_next, ry_next;
  logic signed [ROT_W-1:0]   rnd_x, rnd_y, sh_x, sh_y;
  logic signed [COORD_W-1:0] step_x, step_y;
  logic [COORD_W-1:0]        hw, hh, res_x_c, res_y_c;
  logic [BOX_W-1:0]          res_w_c, res_h_c;
  logic                      turn;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= op_t'(opcode);
      px <= COORD_W'(point_x);
      py <= COORD_W'(point_y);
      r  <= step_length;
      bw <= box_width;
      bh <= box_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        window_width <= cfg_data;
      end else if (cfg_index == CFG_IDX_HEIGHT) begin
        window_height <= cfg_data;
      end
    end
  end

  // exact difference to the target and the snap window test
  always_comb begin
    dx_c  = DIFF_W'(px) - DIFF_W'(cam_x);
    dy_c  = DIFF_W'(py) - DIFF_W'(cam_y);
    adx_c = dx_c[DIFF_W-1] ? -dx_c : dx_c;
    ady_c = dy_c[DIFF_W-1] ? -dy_c : dy_c;
    dxf_c = dx[DIFF_W-1] ? -dx : dx;
    dyf_c = dx[DIFF_W-1] ? -dy : dy;
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx      <= dx_c;
      dy      <= dy_c;
      ax      <= adx_c[STEP_W-1:0];
      ay      <= ady_c[STEP_W-1:0];
      in_span <= (adx_c[DIFF_W-1:STEP_W] == '0) && (ady_c[DIFF_W-1:STEP_W] == '0);
    end
  end

  // one shared multiplier: squares, then step length times inverse gain
  always_comb begin
    mul_a = r;
    mul_b = GAIN_INV;
    if (cmd.sq_x) begin
      mul_a = ax;
      mul_b = MUL_B_W'(ax);
    end else if (cmd.sq_y) begin
      mul_a = ay;
      mul_b = MUL_B_W'(ay);
    end else if (cmd.sq_r) begin
      mul_a = r;
      mul_b = MUL_B_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_x || cmd.sq_y || cmd.sq_r || cmd.gain) begin
      prod <= MUL_W'(mul_a) * MUL_W'(mul_b);
    end
    if (cmd.sq_y) begin
      acc <= ACC_W'(prod);
    end else if (cmd.sq_r) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // cordic iteration: vectoring decides, rotation follows in the same cycle
  always_comb begin
    vx_sh = vx >>> iter;
    vy_sh = vy >>> iter;
    rx_sh = rx >>> iter;
    ry_sh = ry >>> iter;
    turn  = !vy[VEC_W-1];
    if (turn) begin
      vx_next = vx + vy_sh;
      vy_next = vy - vx_sh;
      rx_next = rx - ry_sh;
      ry_next = ry + rx_sh;
    end else begin
      vx_next = vx - vy_sh;
      vy_next = vy + vx_sh;
      rx_next = rx + ry_sh;
      ry_next = ry - rx_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      flip <= dx[DIFF_W-1];
      vx   <= VEC_W'(dxf_c) <<< VEC_SCALE;
      vy   <= VEC_W'(dyf_c) <<< VEC_SCALE;
    end else if (cmd.iterate) begin
      vx <= vx_next;
      vy <= vy_next;
    end
    if (cmd.rot_init) begin
      rx   <= signed'(ROT_W'(prod));
      ry   <= '0;
      iter <= '0;
    end else if (cmd.iterate) begin
      rx   <= rx_next;
      ry   <= ry_next;
      iter <= iter + ITER_W'(1);
    end
  end

  // round half up, undo the half-plane flip
  always_comb begin
    rnd_x  = rx + ROT_HALF;
    rnd_y  = ry + ROT_HALF;
    sh_x   = rnd_x >>> ROT_FRAC;
    sh_y   = rnd_y >>> ROT_FRAC;
    step_x = COORD_W'(sh_x);
    step_y = COORD_W'(sh_y);
    if (flip) begin
      step_x = -step_x;
      step_y = -step_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
    end else if (cmd.exec) begin
      case (op)
        OP_SET: begin
          cam_x <= px;
          cam_y <= py;
        end
        OP_SHIFT: begin
          cam_x <= cam_x + px;
          cam_y <= cam_y + py;
        end
        default: ;
      endcase
    end else if (cmd.snap) begin
      cam_x <= px;
      cam_y <= py;
    end else if (cmd.finish) begin
      cam_x <= cam_x + step_x;
      cam_y <= cam_y + step_y;
    end
  end

  // result selection, camera already updated for the camera ops
  always_comb begin
    hw      = COORD_W'(window_width >> 1) << FRAC_BITS;
    hh      = COORD_W'(window_height >> 1) << FRAC_BITS;
    res_x_c = cam_x;
    res_y_c = cam_y;
    res_w_c = '0;
    res_h_c = '0;
    case (op)
      OP_W2S: begin
        res_x_c = hw + px - cam_x;
        res_y_c = hh + py - cam_y;
        res_w_c = bw;
        res_h_c = bh;
      end
      OP_S2W: begin
        res_x_c = cam_x + px - hw;
        res_y_c = cam_y + py - hh;
        res_w_c = bw;
        res_h_c = bh;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_x      <= POINT_W'(signed'(res_x_c));
      result_y      <= POINT_W'(signed'(res_y_c));
      result_width  <= res_w_c;
      result_height <= res_h_c;
    end
  end

  assign status.is_move   = (op == OP_MOVE);
  assign status.snap_hit  = in_span && (acc < ACC_W'(prod));
  assign status.last_iter = (iter == ITER_W'(CORDIC_STEPS - 1));
  assign status.out_free  = !result_valid || !result_stall;

endmodule

/* src/camera_position_unit_core.sv */
// top level of the camera position unit: 2d camera in 8-bit fraction fixed point
//
// usage
//   item channel (item_valid / item_stall): one beat per command, opcode plus
//   point, step length and box size; a beat is taken when valid is high and
//   stall is low. one item is worked on at a time.
//   result channel (result_valid / result_stall): one beat per item, held in an
//   output register, so the next item is taken while a result still waits.
//   config channel (cfg_valid / cfg_ready): window width and height, index 0
//   and 1, always ready; write only while the block is idle.
// steps from accept to result load; no new item is taken before the load
//   set, shift, get, conversions: exec, then out
//   move-toward, snapped: exec, squares of x, y and r, compare, then out
//   move-toward, stepped: as snapped up to compare, then gain, the cordic
//   iterations, final and out; one vectoring and one rotation step per cycle
// reset: camera at the origin, window 640 by 480, no result pending.
// stall: a stalled result holds its register; the sequencer waits in its last
// state until the register frees up, and the item port stays stalled meanwhile.
`include "camera_position_unit_core_assert.svh"

module camera_position_unit_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [2:0]                             opcode,
  input  logic signed [campos_pkg::POINT_W-1:0]  point_x,
  input  logic signed [campos_pkg::POINT_W-1:0]  point_y,
  input  logic [campos_pkg::STEP_W-1:0]          step_length,
  input  logic [campos_pkg::BOX_W-1:0]           box_width,
  input  logic [campos_pkg::BOX_W-1:0]           box_height,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [campos_pkg::POINT_W-1:0]  result_x,
  output logic signed [campos_pkg::POINT_W-1:0]  result_y,
  output logic [campos_pkg::BOX_W-1:0]           result_width,
  output logic [campos_pkg::BOX_W-1:0]           result_height,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [campos_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [campos_pkg::WIN_W-1:0]           cfg_data
);
  import campos_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // sequencer: steps one item through capture, squares, snap test, cordic
  campos_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: camera registers, shared multiplier, cordic pair, output register
  campos_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .point_x       (point_x),
    .point_y       (point_y),
    .step_length   (step_length),
    .box_width     (box_width),
    .box_height    (box_height),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_x      (result_x),
    .result_y      (result_y),
    .result_width  (result_width),
    .result_height (result_height)
  );

  // the port goes busy right after taking an item
  `CAMPOS_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "item port not busy after accept")
  // a pending result is never overwritten
  `CAMPOS_ASSERT_SAME(a_no_overwrite, cmd.load_out, status.out_free, "result register overwritten")
  // the shared multiplier has one user at a time
  `CAMPOS_ASSERT_SAME(a_one_mul_user, 1'b1, $onehot0({cmd.sq_x, cmd.sq_y, cmd.sq_r, cmd.gain}), "multiplier claimed twice")
  // a loaded result shows up on the port
  `CAMPOS_ASSERT_NEXT(a_load_shows, cmd.load_out, result_valid, "loaded result not valid")

endmodule
